### sv/rgb_box_blur_3x3_or_5x5_assert.svh
// Assertion macros shared by the box blur RTL.
// Depends on nothing; included by the top level.
`ifndef RGB_BOX_BLUR_3X3_OR_5X5_ASSERT_SVH
`define RGB_BOX_BLUR_3X3_OR_5X5_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define BBX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bbx: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define BBX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bbx: next-cycle check failed");

`endif

### sv/bbx_pkg.sv
// Types and constants of the RGB box blur.
// Depends on nothing; used by the cell, raster and top modules and the testbench.
`timescale 1ns / 1ps

package bbx_pkg;

    // Channel and configuration widths.
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CENTRE_W   = 10;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

    // Frame sizes below this are raised to it.
    localparam int MIN_SIZE = 5;

    // Window geometry: cell counts, stored lines and the radius per mode, the first valid centre offset.
    localparam int NUM_CELLS   = 5;
    localparam int SMALL_CELLS = 3;
    localparam int STORE_LINES = 4;
    localparam int RADIUS3     = 1;
    localparam int RADIUS5     = 2;

    // Sum widths: one column of three or five pixels, a whole window.
    localparam int SUM3_W = 10;
    localparam int SUM5_W = 11;
    localparam int WIN3_W = 12;
    localparam int WIN5_W = 13;

    // Floored division by 9 or 25 as a multiply by a rounded-up
    // reciprocal and a right shift; exact for all window sums.
    localparam int RECIP_W   = 15;
    localparam int DIV_SHIFT = 18;
    localparam int PROD_W    = WIN5_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_9  = 15'd29128;
    localparam logic [RECIP_W-1:0] RECIP_25 = 15'd10486;

    // One input item.
    typedef struct packed {
        logic [CH_W-1:0] pixel_red;
        logic [CH_W-1:0] pixel_green;
        logic [CH_W-1:0] pixel_blue;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [CH_W-1:0]     mean_red;
        logic [CH_W-1:0]     mean_green;
        logic [CH_W-1:0]     mean_blue;
        logic [CENTRE_W-1:0] centre_column;
        logic [CENTRE_W-1:0] centre_row;
        logic                frame_done;
    } t_out_item;

    // A pixel viewed as three lanes: 2 red, 1 green, 0 blue.
    typedef logic [2:0][CH_W-1:0] t_pixel_lanes;
    localparam int PIX_W = $bits(t_pixel_lanes);

    // Column sums held by one window cell.
    typedef struct packed {
        logic [2:0][SUM3_W-1:0] sum3;
        logic [2:0][SUM5_W-1:0] sum5;
    } t_col_sums;

    // Window sums accumulated along the cell chain.
    typedef struct packed {
        logic [2:0][WIN3_W-1:0] acc3;
        logic [2:0][WIN5_W-1:0] acc5;
    } t_win_sums;

    // Per-pixel status from the raster counters.
    typedef struct packed {
        logic emit;
        logic frame_done;
    } t_step_flags;

endpackage

### sv/bbx_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; a read at the written address returns the old word.
`timescale 1ns / 1ps

module bbx_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and read-first registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/bbx_cell.sv
// One column cell of the sliding window: holds the column sums of one
// window column and adds them into the sums passing along the chain.
// Depends on bbx_pkg.
`timescale 1ns / 1ps

module bbx_cell #(
    parameter bit IN_SMALL = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  bbx_pkg::t_col_sums   i_sums,
    output bbx_pkg::t_col_sums   o_sums,
    input  bbx_pkg::t_win_sums   i_acc,
    output bbx_pkg::t_win_sums   o_acc
);

    import bbx_pkg::*;

    t_col_sums r_sums;

    // Take the neighbour's column whenever the window moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums <= '0;
        end else if (i_shift) begin
            r_sums <= i_sums;
        end
    end

    assign o_sums = r_sums;

    // Add this column into the running window sums; the three-row sum
    // only counts in cells that lie inside the small window.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            o_acc.acc5[ch] = i_acc.acc5[ch] + WIN5_W'(r_sums.sum5[ch]);
            if (IN_SMALL) begin
                o_acc.acc3[ch] = i_acc.acc3[ch] + WIN3_W'(r_sums.sum3[ch]);
            end else begin
                o_acc.acc3[ch] = i_acc.acc3[ch];
            end
        end
    end

endmodule

### sv/bbx_raster.sv
// Raster position counters with frame-size clamping, plus the per-pixel
// flags that say whether a window is complete and whether the frame ends.
// Depends on bbx_pkg.
`timescale 1ns / 1ps

module bbx_raster #(
    parameter int MAX_LINE_PIXELS = 1024,
    parameter int MAX_FRAME_LINES = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_step,
    input  logic                                 i_window_mode,
    input  logic [bbx_pkg::CFG_DATA_W-1:0]       i_frame_width,
    input  logic [bbx_pkg::CFG_DATA_W-1:0]       i_frame_height,
    output logic [$clog2(MAX_LINE_PIXELS)-1:0]   o_col,
    output logic [$clog2(MAX_FRAME_LINES)-1:0]   o_row,
    output bbx_pkg::t_step_flags                 o_flags
);

    import bbx_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE_PIXELS);
    localparam int ROW_W = $clog2(MAX_FRAME_LINES);
    localparam int CSZ_W = (COL_W + 1 > CFG_DATA_W) ? COL_W + 1 : CFG_DATA_W;
    localparam int RSZ_W = (ROW_W + 1 > CFG_DATA_W) ? ROW_W + 1 : CFG_DATA_W;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [CSZ_W-1:0] w_width;
    logic [RSZ_W-1:0] w_height;
    logic [COL_W-1:0] w_last_col;
    logic [ROW_W-1:0] w_last_row;
    logic             w_at_line_end;
    logic             w_at_last_line;
    logic [2:0]       w_edge;

    assign w_width  = CSZ_W'(i_frame_width);
    assign w_height = RSZ_W'(i_frame_height);

    // Last column of a line, with the width clamped to its legal range.
    always_comb begin
        priority if (w_width < CSZ_W'(MIN_SIZE)) begin
            w_last_col = COL_W'(MIN_SIZE - 1);
        end else if (w_width > CSZ_W'(MAX_LINE_PIXELS)) begin
            w_last_col = COL_W'(MAX_LINE_PIXELS - 1);
        end else begin
            w_last_col = COL_W'(w_width - CSZ_W'(1));
        end
    end

    // Last line of a frame, with the height clamped likewise.
    always_comb begin
        priority if (w_height < RSZ_W'(MIN_SIZE)) begin
            w_last_row = ROW_W'(MIN_SIZE - 1);
        end else if (w_height > RSZ_W'(MAX_FRAME_LINES)) begin
            w_last_row = ROW_W'(MAX_FRAME_LINES - 1);
        end else begin
            w_last_row = ROW_W'(w_height - RSZ_W'(1));
        end
    end

    assign w_at_line_end  = (r_col >= w_last_col);
    assign w_at_last_line = (r_row >= w_last_row);

    // A window is complete once the pixel lies twice the radius
    // beyond the first column and line.
    assign w_edge = i_window_mode ? 3'(2 * RADIUS5) : 3'(2 * RADIUS3);
    assign o_flags.emit       = (r_col >= COL_W'(w_edge)) && (r_row >= ROW_W'(w_edge));
    assign o_flags.frame_done = w_at_line_end && w_at_last_line;

    // Advance the position by one pixel, wrapping at line and frame end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_step) begin
            if (w_at_line_end) begin
                r_col <= '0;
                r_row <= w_at_last_line ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    assign o_col = r_col;
    assign o_row = r_row;

endmodule

### sv/rgb_box_blur_3x3_or_5x5.sv
// RGB 3x3 / 5x5 box mean over a raster pixel stream.
// An accepted item passes the stage 1, 2 and 3 registers into the output register.
// Throughput: one item per cycle unless stalled, set by line-store read and cell chain.
// Reset (synchronous): positions, window cells, valid flags and configuration return
// to their defaults at once; the line store is not cleared and takes no clearing pass.
`timescale 1ns / 1ps
`include "rgb_box_blur_3x3_or_5x5_assert.svh"

module rgb_box_blur_3x3_or_5x5 #(
    parameter int MAX_LINE_PIXELS = 1024,
    parameter int MAX_FRAME_LINES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [bbx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bbx_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bbx_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bbx_pkg::t_out_item              o_out_data
);

    import bbx_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE_PIXELS);
    localparam int ROW_W = $clog2(MAX_FRAME_LINES);

    // Floored mean of a window sum by reciprocal multiplication.
    function automatic logic [CH_W-1:0] mean_of(input logic [WIN5_W-1:0] sum,
                                                input logic mode);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sum) * PROD_W'(mode ? RECIP_25 : RECIP_9);
        return CH_W'(prod >> DIV_SHIFT);
    endfunction

    // Configuration registers.
    logic                  r_window_mode;
    logic [CFG_DATA_W-1:0] r_frame_width;
    logic [CFG_DATA_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_mode  <= 1'b0;
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_WINDOW_MODE:  r_window_mode  <= i_cfg_data[0];
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves while the output register is free or
    // its item is being taken.
    logic w_adv;
    logic w_in_accept;

    assign w_adv       = !o_out_valid || !i_out_stall;
    assign o_in_stall  = !w_adv || !i_rst_n;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // Raster position of the incoming item.
    logic [COL_W-1:0] w_col;
    logic [ROW_W-1:0] w_row;
    t_step_flags      w_flags;

    bbx_raster #(
        .MAX_LINE_PIXELS(MAX_LINE_PIXELS),
        .MAX_FRAME_LINES(MAX_FRAME_LINES)
    ) u_raster (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_in_accept),
        .i_window_mode (r_window_mode),
        .i_frame_width (r_frame_width),
        .i_frame_height(r_frame_height),
        .o_col         (w_col),
        .o_row         (w_row),
        .o_flags       (w_flags)
    );

    // Line store: four line slots, each a RAM indexed by column. The
    // item is written into slot row mod 4 while the same column of all
    // slots is read, which returns the four lines above it.
    t_pixel_lanes w_rd [STORE_LINES];

    for (genvar s = 0; s < STORE_LINES; s++) begin : g_line
        logic [PIX_W-1:0] w_rdata;

        bbx_ram #(
            .WIDTH(PIX_W),
            .DEPTH(MAX_LINE_PIXELS)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_in_accept && (w_row[1:0] == 2'(s))),
            .i_waddr(w_col),
            .i_wdata(PIX_W'(i_in_data)),
            .i_re   (w_in_accept),
            .i_raddr(w_col),
            .o_rdata(w_rdata)
        );

        assign w_rd[s] = w_rdata;
    end

    // Stage 1: item waiting for its line-store column.
    logic                r_s1_valid;
    t_step_flags         r_s1_flags;
    logic                r_s1_mode;
    logic [1:0]          r_s1_slot;
    t_pixel_lanes        r_s1_pix;
    logic [CENTRE_W-1:0] r_s1_ccol;
    logic [CENTRE_W-1:0] r_s1_crow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_flags <= w_flags;
            r_s1_mode  <= r_window_mode;
            r_s1_slot  <= w_row[1:0];
            r_s1_pix   <= i_in_data;
            r_s1_ccol  <= CENTRE_W'(w_col - COL_W'(r_window_mode ? RADIUS5 : RADIUS3));
            r_s1_crow  <= CENTRE_W'(w_row - ROW_W'(r_window_mode ? RADIUS5 : RADIUS3));
        end
    end

    // New window column, oldest line first, and its three- and five-row sums.
    t_pixel_lanes w_colpx [NUM_CELLS];
    t_col_sums    w_new_col;

    always_comb begin
        for (int k = 0; k < STORE_LINES; k++) begin
            w_colpx[k] = w_rd[2'(r_s1_slot + 2'(k))];
        end
        w_colpx[NUM_CELLS-1] = r_s1_pix;
        for (int ch = 0; ch < 3; ch++) begin
            w_new_col.sum3[ch] = SUM3_W'(w_colpx[2][ch]) + SUM3_W'(w_colpx[3][ch])
                               + SUM3_W'(w_colpx[4][ch]);
            w_new_col.sum5[ch] = SUM5_W'(w_new_col.sum3[ch]) + SUM5_W'(w_colpx[0][ch])
                               + SUM5_W'(w_colpx[1][ch]);
        end
    end

    // Stage 2: the window as a chain of column cells. Columns move from
    // the newest cell towards the oldest; sums accumulate the other way.
    logic      w_shift;
    t_col_sums w_cell_sums [NUM_CELLS];
    t_win_sums w_cell_acc  [NUM_CELLS+1];

    assign w_shift       = w_adv && r_s1_valid;
    assign w_cell_acc[0] = '0;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        t_col_sums w_feed;

        if (i == NUM_CELLS - 1) begin : g_newest
            assign w_feed = w_new_col;
        end else begin : g_inner
            assign w_feed = w_cell_sums[i+1];
        end

        bbx_cell #(
            .IN_SMALL(i >= NUM_CELLS - SMALL_CELLS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(w_shift),
            .i_sums (w_feed),
            .o_sums (w_cell_sums[i]),
            .i_acc  (w_cell_acc[i]),
            .o_acc  (w_cell_acc[i+1])
        );
    end

    logic                r_s2_valid;
    logic                r_s2_mode;
    logic                r_s2_done;
    logic [CENTRE_W-1:0] r_s2_ccol;
    logic [CENTRE_W-1:0] r_s2_crow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid && r_s1_flags.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_s2_mode <= r_s1_mode;
            r_s2_done <= r_s1_flags.frame_done;
            r_s2_ccol <= r_s1_ccol;
            r_s2_crow <= r_s1_crow;
        end
    end

    // Stage 3: window sums for the chosen size.
    logic                          r_s3_valid;
    logic                          r_s3_mode;
    logic                          r_s3_done;
    logic [CENTRE_W-1:0]           r_s3_ccol;
    logic [CENTRE_W-1:0]           r_s3_crow;
    logic [2:0][WIN5_W-1:0]        r_s3_sum;
    t_win_sums                     w_total;

    assign w_total = w_cell_acc[NUM_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_mode <= r_s2_mode;
            r_s3_done <= r_s2_done;
            r_s3_ccol <= r_s2_ccol;
            r_s3_crow <= r_s2_crow;
            for (int ch = 0; ch < 3; ch++) begin
                r_s3_sum[ch] <= r_s2_mode ? w_total.acc5[ch] : WIN5_W'(w_total.acc3[ch]);
            end
        end
    end

    // Output register: the divided means and the centre position.
    logic      r_out_valid;
    t_out_item r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data.mean_red      <= mean_of(r_s3_sum[2], r_s3_mode);
            r_out_data.mean_green    <= mean_of(r_s3_sum[1], r_s3_mode);
            r_out_data.mean_blue     <= mean_of(r_s3_sum[0], r_s3_mode);
            r_out_data.centre_column <= r_s3_ccol;
            r_out_data.centre_row    <= r_s3_crow;
            r_out_data.frame_done    <= r_s3_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // An accepted item always occupies the first stage next cycle.
    `BBX_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, w_in_accept, r_s1_valid)
    // No item is taken while a result waits behind a stalled receiver.
    `BBX_ASSERT_IMPL(a_blocked_no_accept, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)
    // Each advance moves the last stage into the output register.
    `BBX_ASSERT_NEXT(a_out_follows, i_clk, i_rst_n, w_adv, o_out_valid == $past(r_s3_valid))

endmodule

### verif/tb_top.sv
// Self-checking testbench of the RGB 3x3 / 5x5 box mean.
// Depends on bbx_pkg and rgb_box_blur_3x3_or_5x5; predicts every mean in step with the stream.
`timescale 1ns / 1ps

module tb_top;
    import bbx_pkg::*;

    localparam int LINE_PIXELS  = 1024;
    localparam int FRAME_LINES  = 1024;
    localparam int LATENCY      = 3;
    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 300;
    localparam int IDLE_PERCENT = 8;
    localparam int WIDE_PIXELS  = 48;
    localparam int TALL_LINES   = 32;

    // Register index with no register behind it; writes to it are ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam bit MODE_3X3 = 1'b0;
    localparam bit MODE_5X5 = 1'b1;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;

    // Predictor state: line store, window and raster position.
    bit [PIX_W-1:0]  line_mem [STORE_LINES][LINE_PIXELS];
    bit [PIX_W-1:0]  win [NUM_CELLS][NUM_CELLS];
    int unsigned     next_col = 0;
    int unsigned     next_row = 0;
    bit              model_mode = MODE_3X3;
    bit [CFG_DATA_W-1:0] model_width  = FRAME_WIDTH_RESET;
    bit [CFG_DATA_W-1:0] model_height = FRAME_HEIGHT_RESET;

    t_out_item   expected_means [$];
    int unsigned fail_count  = 0;
    int unsigned pixels_sent = 0;
    int unsigned quiet_cycles = 0;
    bit          calm = 1'b0;

    rgb_box_blur_3x3_or_5x5 u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random unless a calm stretch is running.
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    function automatic int unsigned clamp_size(input bit [CFG_DATA_W-1:0] raw,
                                               input int unsigned hi);
        if (raw < MIN_SIZE) return MIN_SIZE;
        if (raw > hi) return hi;
        return raw;
    endfunction

    // Advances the window by one pixel and queues the mean it completes, if any.
    function automatic void blur_pixel(input t_in_item px);
        int unsigned w, h, col, row, span, first, divisor;
        int unsigned sum_r, sum_g, sum_b;
        int c, k;
        t_out_item res;
        w = clamp_size(model_width, LINE_PIXELS);
        h = clamp_size(model_height, FRAME_LINES);
        col = next_col;
        row = next_row;
        for (c = 0; c < NUM_CELLS - 1; c++)
            for (k = 0; k < NUM_CELLS; k++)
                win[c][k] = win[c + 1][k];
        for (k = 0; k < STORE_LINES; k++)
            win[NUM_CELLS - 1][k] = line_mem[(row + k) % STORE_LINES][col];
        win[NUM_CELLS - 1][NUM_CELLS - 1] = px;
        line_mem[row % STORE_LINES][col] = px;

        span = model_mode ? NUM_CELLS : SMALL_CELLS;
        if (col >= span - 1 && row >= span - 1) begin
            first = NUM_CELLS - span;
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (c = first; c < NUM_CELLS; c++)
                for (k = first; k < NUM_CELLS; k++) begin
                    sum_r += win[c][k][23:16];
                    sum_g += win[c][k][15:8];
                    sum_b += win[c][k][7:0];
                end
            divisor = span * span;
            res.mean_red      = CH_W'(sum_r / divisor);
            res.mean_green    = CH_W'(sum_g / divisor);
            res.mean_blue     = CH_W'(sum_b / divisor);
            res.centre_column = CENTRE_W'(col - span / 2);
            res.centre_row    = CENTRE_W'(row - span / 2);
            res.frame_done    = (col >= w - 1) && (row >= h - 1);
            expected_means.push_back(res);
        end

        // Raster position: wrap the column at the line end, the row at the frame end.
        if (col >= w - 1) begin
            next_col = 0;
            next_row = (row >= h - 1) ? 0 : row + 1;
        end else begin
            next_col = col + 1;
        end
    endfunction

    function automatic logic [CH_W-1:0] random_channel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    // Offers one item, with random idle cycles in front, and waits for it to be taken.
    task automatic send_pixel(input t_in_item px);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do @(posedge clk); while (in_stall);
        blur_pixel(px);
        pixels_sent++;
    endtask

    task automatic send_random_pixels(input int unsigned count);
        t_in_item px;
        repeat (count) begin
            px.pixel_red   = random_channel();
            px.pixel_green = random_channel();
            px.pixel_blue  = random_channel();
            send_pixel(px);
        end
    endtask

    // Lets the block run empty so that a register may be written.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_WINDOW_MODE:  model_mode   = value[0];
            CFG_FRAME_WIDTH:  model_width  = value;
            CFG_FRAME_HEIGHT: model_height = value;
            default: ;
        endcase
    endtask

    // The mode register only looks at bit 0; the upper bits carry noise.
    task automatic configure_frame(input bit mode, input logic [CFG_DATA_W-1:0] width,
                                   input logic [CFG_DATA_W-1:0] height);
        write_reg(CFG_WINDOW_MODE, {(CFG_DATA_W - 1)'($urandom), mode});
        write_reg(CFG_FRAME_WIDTH, width);
        write_reg(CFG_FRAME_HEIGHT, height);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compares every result taken from the block with the oldest prediction.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_means.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %p", $time, out_data);
                fail_count++;
            end else begin
                want = expected_means.pop_front();
                check_field("mean_red", want.mean_red, out_data.mean_red);
                check_field("mean_green", want.mean_green, out_data.mean_green);
                check_field("mean_blue", want.mean_blue, out_data.mean_blue);
                check_field("centre_column", want.centre_column, out_data.centre_column);
                check_field("centre_row", want.centre_row, out_data.centre_row);
                check_field("frame_done", want.frame_done, out_data.frame_done);
            end
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Saturated, empty and ramped channels in both window sizes; undersized frame
    // registers are raised to the minimum and the spare index changes nothing.
    task automatic test_directed_extremes();
        int i;
        configure_frame(MODE_5X5, 11'd5, 11'd5);
        for (i = 0; i < 25; i++)
            send_pixel(t_in_item'{pixel_red: '1, pixel_green: '0,
                                  pixel_blue: CH_W'(i * 10)});
        drain_results();
        write_reg(CFG_SPARE, '1);
        configure_frame(MODE_3X3, 11'd2, 11'd0);
        for (i = 0; i < 25; i++)
            send_pixel(t_in_item'{pixel_red: CH_W'(255 - i * 10), pixel_green: '1,
                                  pixel_blue: (i % 2) ? '1 : '0});
        drain_results();
    endtask

    // A long line and the shortest frame, with neither side idling.
    task automatic test_wide_frame();
        calm = 1'b1;
        configure_frame(MODE_5X5, CFG_DATA_W'(WIDE_PIXELS), 11'd4);
        send_random_pixels(WIDE_PIXELS * MIN_SIZE);
        drain_results();
        calm = 1'b0;
    endtask

    // A tall, narrow frame: an undersized width is raised to the minimum.
    task automatic test_tall_frame();
        configure_frame(MODE_3X3, 11'd3, CFG_DATA_W'(TALL_LINES));
        send_random_pixels(MIN_SIZE * TALL_LINES);
        drain_results();
    endtask

    // A mode change halfway down a frame applies from the next item on.
    task automatic test_mode_change_mid_frame();
        configure_frame(MODE_3X3, 11'd8, 11'd8);
        send_random_pixels(32);
        drain_results();
        write_reg(CFG_WINDOW_MODE, {(CFG_DATA_W - 1)'($urandom), MODE_5X5});
        send_random_pixels(32);
        drain_results();
    endtask

    // Whole frames of random small sizes and modes, undersized values now and then.
    task automatic test_random_frames();
        int unsigned start;
        logic [CFG_DATA_W-1:0] width, height;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_ITEMS) begin
            width  = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(4))
                                              : CFG_DATA_W'($urandom_range(5, 14));
            height = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(4))
                                              : CFG_DATA_W'($urandom_range(5, 10));
            configure_frame(1'($urandom_range(1)), width, height);
            send_random_pixels(clamp_size(width, LINE_PIXELS) *
                               clamp_size(height, FRAME_LINES));
            drain_results();
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_wide_frame();
        test_tall_frame();
        test_mode_change_mid_frame();
        test_random_frames();
        drain_results();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### rgb_box_blur_3x3_or_5x5.f
+incdir+sv
sv/bbx_pkg.sv
sv/bbx_ram.sv
sv/bbx_cell.sv
sv/bbx_raster.sv
sv/rgb_box_blur_3x3_or_5x5.sv
verif/tb_top.sv
